[rtl/stt_pkg.sv]
// Shared types, character constants and byte classifiers for the scene text tokenizer.
// No dependencies; stt_step, the top level and the bench import this package.
`default_nettype none
package stt_pkg;

    // Characters the scanner reacts to
    localparam logic [7:0] CH_CTRL_Z = 8'h1A;
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_QUOTE  = 8'h27;  // '\''
    localparam logic [7:0] CH_AT     = 8'h40;  // '@'
    localparam logic [7:0] CH_E      = 8'h65;  // 'e'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\\'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_UNDER  = 8'h5F;  // '_'
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Bit positions of the per-item run mask, in output order
    localparam int RB_ZERO    = 0;  // appended '0' of a dangling exponent
    localparam int RB_END     = 1;  // token end with the run's class
    localparam int RB_CHAR    = 2;  // the input byte as a token character
    localparam int RB_SPECIAL = 3;  // token end of a lone special character
    localparam int RUN_SLOTS  = 4;

    typedef enum logic [3:0] {
        SC_START   = 4'd0,
        SC_INT     = 4'd1,
        SC_FLOAT   = 4'd2,
        SC_WORD    = 4'd3,
        SC_IDENT   = 4'd4,
        SC_PATH    = 4'd5,
        SC_COMMENT = 4'd8,
        SC_QUOTE   = 4'd9
    } t_scan;

    typedef enum logic [1:0] {
        PH_MANT    = 2'd0,
        PH_AFTER_E = 2'd1,
        PH_EXP     = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        CL_END       = 4'd0,
        CL_INT       = 4'd1,
        CL_FLOAT     = 4'd2,
        CL_WORD      = 4'd3,
        CL_IDENT     = 4'd4,
        CL_PATH      = 4'd5,
        CL_SPECIAL   = 4'd6,
        CL_ERROR     = 4'd7,
        CL_EOF_CMT   = 4'd8,
        CL_EOF_QUOTE = 4'd9
    } t_cls;

    // Results one item causes, drained lowest mask bit first
    typedef struct packed {
        logic [RUN_SLOTS-1:0] mask;
        t_cls                 cls;
        logic [7:0]           ch;
    } t_run;

    // Scanner state plus the run for one item
    typedef struct packed {
        t_scan  state;
        t_phase phase;
        logic   plus;
        t_run   run;
    } t_step;

    // Outcome of scanning a byte from the start state
    typedef struct packed {
        t_scan  state;
        t_phase phase;
        logic   plus;
        logic   put;
        logic   special;
    } t_start;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_fnum(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || is_digit(c);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_fill(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_path_sep(input logic [7:0] c);
        return (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_COLON) ||
               (c == CH_DOT) || (c == CH_STAR);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c == CH_UNDER) || (c == CH_MINUS) || is_digit(c) || is_letter(c);
    endfunction

    // Classify a byte as the first character of a token
    function automatic t_start scan_start(input logic [7:0] c, input t_phase ph,
                                          input logic pl);
        t_start s;
        s.state   = SC_START;
        s.phase   = ph;
        s.plus    = pl;
        s.put     = 1'b0;
        s.special = 1'b0;
        if (is_fnum(c)) begin
            s.state = SC_INT;
            s.plus  = (c == CH_PLUS);
            s.put   = 1'b1;
        end else if (c == CH_DOT) begin
            s.state = SC_FLOAT;
            s.phase = PH_MANT;
            s.put   = 1'b1;
        end else if (is_letter(c)) begin
            s.state = SC_WORD;
            s.put   = 1'b1;
        end else if ((c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_COLON) ||
                     (c == CH_AT)) begin
            s.state = SC_PATH;
            s.put   = 1'b1;
        end else if (c == CH_HASH) begin
            s.state = SC_COMMENT;
        end else if (c == CH_QUOTE) begin
            s.state = SC_QUOTE;
        end else if (!is_fill(c)) begin
            // lone special character: emitted and closed at once
            s.put     = 1'b1;
            s.special = 1'b1;
            s.phase   = PH_MANT;
            s.plus    = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/stt_ifs.sv]
// Valid/ready channel interfaces for the scene text tokenizer input and result streams.
// Depends on nothing; payload widths follow the field definitions.
`default_nettype none
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface stt_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] char_value;
    logic [3:0] token_class;
    logic       last_of_run;

    modport source (output valid, output result_kind, output char_value,
                    output token_class, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input char_value,
                    input token_class, input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/stt_step.sv]
// Next-state and result-run logic of the tokenizer for one input item.
// Depends on stt_pkg (state codes, classes, byte classifiers).
`default_nettype none
module stt_step
    import stt_pkg::*;
(
    input  wire logic       i_kind,
    input  wire logic [7:0] i_byte,
    input  wire t_scan      i_state,
    input  wire t_phase     i_phase,
    input  wire logic       i_plus,
    output t_step           o_step
);

    t_start s_dflt;
    t_start s_push;

    // Start-state scans: in place, and after a token end (cleared phase and sign)
    assign s_dflt = scan_start(i_byte, i_phase, i_plus);
    assign s_push = scan_start(i_byte, PH_MANT, 1'b0);

    always_comb begin
        logic  do_end;
        logic  restart;
        logic  do_start;
        logic  do_put;
        logic  do_zero;
        logic  fall;
        t_cls  end_cls;
        t_scan ns;
        t_phase nph;
        logic  npl;

        do_end   = 1'b0;
        restart  = 1'b0;
        do_start = 1'b0;
        do_put   = 1'b0;
        do_zero  = 1'b0;
        fall     = 1'b0;
        end_cls  = CL_END;
        ns       = i_state;
        nph      = i_phase;
        npl      = i_plus;

        if (i_kind) begin
            // end of input closes whatever is open
            do_end = 1'b1;
            case (i_state)
                SC_INT:     end_cls = CL_INT;
                SC_FLOAT:   end_cls = CL_FLOAT;
                SC_WORD:    end_cls = CL_WORD;
                SC_IDENT:   end_cls = CL_IDENT;
                SC_PATH:    end_cls = CL_PATH;
                SC_COMMENT: end_cls = CL_EOF_CMT;
                SC_QUOTE:   end_cls = CL_EOF_QUOTE;
                default:    end_cls = CL_END;
            endcase
        end else if (i_byte == CH_CTRL_Z) begin
            // ignored byte: no results, state kept
        end else if (((i_state == SC_INT) || (i_state == SC_FLOAT) || (i_state == SC_WORD) ||
                      (i_state == SC_IDENT) || (i_state == SC_PATH)) && is_fill(i_byte)) begin
            do_end = 1'b1;
            case (i_state)
                SC_INT:   end_cls = CL_INT;
                SC_FLOAT: end_cls = CL_FLOAT;
                SC_WORD:  end_cls = CL_WORD;
                SC_IDENT: end_cls = CL_IDENT;
                default:  end_cls = CL_PATH;
            endcase
        end else begin
            case (i_state)
                SC_INT: begin
                    if (is_fnum(i_byte)) begin
                        do_put = 1'b1;
                    end else if (i_byte == CH_DOT) begin
                        ns = SC_FLOAT; nph = PH_MANT; do_put = 1'b1;
                    end else if (i_byte == CH_E) begin
                        ns = SC_FLOAT; nph = PH_AFTER_E; do_put = 1'b1;
                    end else if (is_letter(i_byte)) begin
                        if (i_plus) begin
                            do_end = 1'b1; restart = 1'b1; end_cls = CL_INT;
                        end else begin
                            ns = SC_IDENT; do_put = 1'b1;
                        end
                    end else begin
                        do_end = 1'b1; end_cls = CL_ERROR;
                    end
                end
                SC_FLOAT: begin
                    case (i_phase)
                        PH_MANT: begin
                            if (is_digit(i_byte)) do_put = 1'b1;
                            else if (i_byte == CH_E) begin
                                nph = PH_AFTER_E; do_put = 1'b1;
                            end else fall = 1'b1;
                        end
                        PH_AFTER_E: begin
                            if (is_fnum(i_byte)) begin
                                nph = PH_EXP; do_put = 1'b1;
                            end else begin
                                // dangling exponent: append '0', close, rescan
                                do_zero = 1'b1; do_end = 1'b1; restart = 1'b1;
                                end_cls = CL_FLOAT;
                            end
                        end
                        default: begin
                            if (is_digit(i_byte)) do_put = 1'b1;
                            else fall = 1'b1;
                        end
                    endcase
                    if (fall) begin
                        do_end = 1'b1;
                        if (is_letter(i_byte)) begin
                            restart = 1'b1; end_cls = CL_FLOAT;
                        end else begin
                            end_cls = CL_ERROR;
                        end
                    end
                end
                SC_WORD: begin
                    if (is_letter(i_byte)) begin
                        do_put = 1'b1;
                    end else if ((i_byte == CH_UNDER) || (i_byte == CH_MINUS) ||
                                 is_digit(i_byte)) begin
                        ns = SC_IDENT; do_put = 1'b1;
                    end else if (is_path_sep(i_byte)) begin
                        ns = SC_PATH; do_put = 1'b1;
                    end else if (i_byte == CH_PLUS) begin
                        do_end = 1'b1; restart = 1'b1; end_cls = CL_WORD;
                    end else begin
                        do_end = 1'b1; end_cls = CL_ERROR;
                    end
                end
                SC_IDENT: begin
                    if (is_ident(i_byte)) begin
                        do_put = 1'b1;
                    end else if (is_path_sep(i_byte)) begin
                        ns = SC_PATH; do_put = 1'b1;
                    end else if (i_byte == CH_PLUS) begin
                        do_end = 1'b1; restart = 1'b1; end_cls = CL_IDENT;
                    end else begin
                        do_end = 1'b1; end_cls = CL_ERROR;
                    end
                end
                SC_PATH: begin
                    if (is_ident(i_byte) || is_path_sep(i_byte)) begin
                        do_put = 1'b1;
                    end else if (i_byte == CH_PLUS) begin
                        do_end = 1'b1; restart = 1'b1; end_cls = CL_PATH;
                    end else begin
                        do_end = 1'b1; end_cls = CL_ERROR;
                    end
                end
                SC_COMMENT: begin
                    // comment runs to a line end or NUL, silently
                    if ((i_byte == CH_LF) || (i_byte == CH_CR) || (i_byte == CH_NUL))
                        ns = SC_START;
                end
                SC_QUOTE: begin
                    if (i_byte == CH_QUOTE) begin
                        do_end = 1'b1; end_cls = CL_PATH;
                    end else begin
                        do_put = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        o_step.run.mask          = '0;
        o_step.run.cls           = end_cls;
        o_step.run.ch            = i_byte;
        o_step.run.mask[RB_ZERO] = do_zero;

        // close the token, then rescan the byte from the start state if pushed back
        if (do_end) begin
            o_step.run.mask[RB_END] = 1'b1;
            ns  = SC_START;
            nph = PH_MANT;
            npl = 1'b0;
            if (restart) begin
                ns  = s_push.state;
                nph = s_push.phase;
                npl = s_push.plus;
                o_step.run.mask[RB_CHAR]    = s_push.put;
                o_step.run.mask[RB_SPECIAL] = s_push.special;
            end
        end
        if (do_start) begin
            ns  = s_dflt.state;
            nph = s_dflt.phase;
            npl = s_dflt.plus;
            o_step.run.mask[RB_CHAR]    = s_dflt.put;
            o_step.run.mask[RB_SPECIAL] = s_dflt.special;
        end
        if (do_put) o_step.run.mask[RB_CHAR] = 1'b1;

        o_step.state = ns;
        o_step.phase = nph;
        o_step.plus  = npl;
    end

endmodule
`default_nettype wire

[rtl/scene_text_tokenizer.sv]
// Scene text tokenizer top level: scanner state, two-entry run queue and result drain.
// Depends on stt_pkg, stt_in_if / stt_out_if and stt_step.
//
// Usage:
//   i_in  carries one item per transfer: kind (0 data byte, 1 end of input) and
//         byte_value. o_out carries results: a token character (result_kind 0,
//         char_value) or a token end (result_kind 1, token_class); last_of_run
//         marks the final result caused by one input item.
//   An item is scanned in the cycle it is transferred; its results (zero to four)
//   go into a two-entry queue of runs and are presented from the registered head
//   entry, one result per cycle while the receiver is ready.
//   Throughput: one item per cycle while each item causes at most one result and
//   the receiver is ready; an item with several results holds the output until
//   all are presented, so the output port sets the sustained rate. Items that cause
//   no result (Ctrl-Z, whitespace at start, comment bytes) never enter the queue.
//   Reset (i_rst_n low, synchronous) returns the scanner to the start state and
//   empties the queue. While the receiver stalls, the presented result holds and
//   one further item is still taken into the second queue entry; ready then drops
//   until the head run finishes draining.
`default_nettype none
module scene_text_tokenizer
    import stt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_in,
    stt_out_if.source  o_out
);

    t_scan  r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_plus,  n_plus;
    logic   r_hv, r_tv;
    t_run   r_head, r_tail;
    t_step  step;

    logic                 in_fire;
    logic                 push;
    logic                 head_done;
    logic                 head_free;
    logic [RUN_SLOTS-1:0] lowest;
    logic [RUN_SLOTS-1:0] rest;

    stt_step u_step (
        .i_kind  (i_in.kind),
        .i_byte  (i_in.byte_value),
        .i_state (r_state),
        .i_phase (r_phase),
        .i_plus  (r_plus),
        .o_step  (step)
    );

    // Pick the next result of the head run
    assign lowest    = r_head.mask & (~r_head.mask + {{(RUN_SLOTS-1){1'b0}}, 1'b1});
    assign rest      = r_head.mask & ~lowest;
    assign head_done = r_hv && o_out.ready && (rest == '0);
    assign head_free = !r_hv || head_done;

    assign i_in.ready = !r_tv || head_done;
    assign in_fire    = i_in.valid && i_in.ready;
    assign push       = in_fire && (step.run.mask != '0);

    // Present the head result
    always_comb begin
        o_out.valid       = r_hv;
        o_out.last_of_run = (rest == '0);
        o_out.result_kind = 1'b1;
        o_out.char_value  = '0;
        o_out.token_class = CL_END;
        if (lowest[RB_ZERO]) begin
            o_out.result_kind = 1'b0;
            o_out.char_value  = CH_ZERO;
        end else if (lowest[RB_END]) begin
            o_out.token_class = r_head.cls;
        end else if (lowest[RB_CHAR]) begin
            o_out.result_kind = 1'b0;
            o_out.char_value  = r_head.ch;
        end else begin
            o_out.token_class = CL_SPECIAL;
        end
    end

    // Advance scanner state on each input transfer
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_plus  = r_plus;
        if (in_fire) begin
            n_state = step.state;
            n_phase = step.phase;
            n_plus  = step.plus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_START;
            r_phase <= PH_MANT;
            r_plus  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_plus  <= n_plus;
        end
    end

    // Run queue: drain the head, refill from tail or the new item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_tv <= 1'b0;
        end else if (head_free) begin
            if (r_tv) begin
                r_hv <= 1'b1;
                r_tv <= push;
            end else begin
                r_hv <= push;
                r_tv <= 1'b0;
            end
        end else if (push) begin
            r_tv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_free) begin
            if (r_tv) begin
                r_head <= r_tail;
                r_tail <= step.run;
            end else begin
                r_head <= step.run;
            end
        end else begin
            if (r_hv && o_out.ready) r_head.mask <= rest;
            if (push) r_tail <= step.run;
        end
    end

    // A presented run always has a result left
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> (r_head.mask != '0))
        else $error("head run valid with empty mask");

    // The tail entry is only used behind a valid head
    a_tail_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> r_hv)
        else $error("tail run valid without head run");

    // A full queue takes an item only as the head finishes
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_tv) |-> head_done)
        else $error("input transfer into full run queue");

    // Scanner state moves only on an input transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_state))
        else $error("scanner state changed without input transfer");

endmodule
`default_nettype wire

[bench/tb_scene_text_tokenizer.sv]
// Self-checking bench for scene_text_tokenizer: byte stream in, token characters and token ends out.
// Depends on stt_pkg, stt_in_if / stt_out_if and the scene_text_tokenizer top level.
`default_nettype none
module tb_scene_text_tokenizer;
    import stt_pkg::*;

    // One expected or observed result
    typedef struct packed {
        logic       rkind;
        logic [7:0] ch;
        logic [3:0] cls;
        logic       last;
    } t_tok_res;

    logic clk;
    logic rst_n;

    stt_in_if  in_ch ();
    stt_out_if out_ch ();

    scene_text_tokenizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Scanner copy kept by the bench
    t_scan  scan_st;
    t_phase fphase;
    logic   plus_lead;

    t_tok_res expected_tokens[$];
    int       step_count;
    int       errors     = 0;
    int       items_sent = 0;
    int       hold_left  = 0;
    bit       send_idle  = 1'b1;
    bit       recv_idle  = 1'b1;

    // Generate the clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte classes
    // ------------------------------------------------------------------
    function automatic logic ch_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic ch_numlead(input logic [7:0] c);
        return ch_digit(c) || (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic ch_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic ch_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic ch_sep(input logic [7:0] c);
        return (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_COLON) ||
               (c == CH_DOT) || (c == CH_STAR);
    endfunction

    function automatic logic ch_idchar(input logic [7:0] c);
        return ch_alpha(c) || ch_digit(c) || (c == CH_UNDER) || (c == CH_MINUS);
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic void emit_char(input logic [7:0] c);
        t_tok_res r;
        r.rkind = 1'b0;
        r.ch    = c;
        r.cls   = CL_END;
        r.last  = 1'b0;
        expected_tokens.push_back(r);
        step_count++;
    endfunction

    function automatic void close_token(input t_cls cl);
        t_tok_res r;
        r.rkind = 1'b1;
        r.ch    = 8'h00;
        r.cls   = cl;
        r.last  = 1'b0;
        expected_tokens.push_back(r);
        step_count++;
        scan_st   = SC_START;
        fphase    = PH_MANT;
        plus_lead = 1'b0;
    endfunction

    function automatic t_cls state_class(input t_scan s);
        case (s)
            SC_INT:     return CL_INT;
            SC_FLOAT:   return CL_FLOAT;
            SC_WORD:    return CL_WORD;
            SC_IDENT:   return CL_IDENT;
            SC_PATH:    return CL_PATH;
            SC_COMMENT: return CL_EOF_CMT;
            SC_QUOTE:   return CL_EOF_QUOTE;
            default:    return CL_END;
        endcase
    endfunction

    // Classify the first byte of a token
    function automatic void open_token(input logic [7:0] c);
        scan_st = SC_START;
        if (ch_numlead(c)) begin
            scan_st   = SC_INT;
            plus_lead = (c == CH_PLUS);
            emit_char(c);
        end else if (c == CH_DOT) begin
            scan_st = SC_FLOAT;
            fphase  = PH_MANT;
            emit_char(c);
        end else if (ch_alpha(c)) begin
            scan_st = SC_WORD;
            emit_char(c);
        end else if (c == CH_BSLASH || c == CH_SLASH || c == CH_COLON || c == CH_AT) begin
            scan_st = SC_PATH;
            emit_char(c);
        end else if (c == CH_HASH) begin
            scan_st = SC_COMMENT;
        end else if (c == CH_QUOTE) begin
            scan_st = SC_QUOTE;
        end else if (!ch_blank(c)) begin
            emit_char(c);
            close_token(CL_SPECIAL);
        end
    endfunction

    // Close the token and rescan the byte from the start state
    function automatic void reopen(input t_cls cl, input logic [7:0] c);
        close_token(cl);
        open_token(c);
    endfunction

    function automatic void scan_float(input logic [7:0] c);
        if (fphase == PH_AFTER_E) begin
            if (ch_numlead(c)) begin
                fphase = PH_EXP;
                emit_char(c);
            end else begin
                // dangling exponent: pad with a zero digit
                emit_char(CH_ZERO);
                reopen(CL_FLOAT, c);
            end
        end else if (ch_digit(c)) begin
            emit_char(c);
        end else if (fphase == PH_MANT && c == CH_E) begin
            fphase = PH_AFTER_E;
            emit_char(c);
        end else if (ch_alpha(c)) begin
            reopen(CL_FLOAT, c);
        end else begin
            close_token(CL_ERROR);
        end
    endfunction

    function automatic void scan_data(input logic [7:0] c);
        // whitespace ends any open token and is dropped
        if (scan_st inside {SC_INT, SC_FLOAT, SC_WORD, SC_IDENT, SC_PATH} && ch_blank(c)) begin
            close_token(state_class(scan_st));
            return;
        end
        case (scan_st)
            SC_INT: begin
                if (ch_numlead(c)) begin
                    emit_char(c);
                end else if (c == CH_DOT) begin
                    scan_st = SC_FLOAT;
                    fphase  = PH_MANT;
                    emit_char(c);
                end else if (c == CH_E) begin
                    scan_st = SC_FLOAT;
                    fphase  = PH_AFTER_E;
                    emit_char(c);
                end else if (ch_alpha(c)) begin
                    if (plus_lead) begin
                        reopen(CL_INT, c);
                    end else begin
                        scan_st = SC_IDENT;
                        emit_char(c);
                    end
                end else begin
                    close_token(CL_ERROR);
                end
            end
            SC_FLOAT: scan_float(c);
            SC_WORD: begin
                if (ch_alpha(c)) begin
                    emit_char(c);
                end else if (ch_idchar(c)) begin
                    scan_st = SC_IDENT;
                    emit_char(c);
                end else if (ch_sep(c)) begin
                    scan_st = SC_PATH;
                    emit_char(c);
                end else if (c == CH_PLUS) begin
                    reopen(CL_WORD, c);
                end else begin
                    close_token(CL_ERROR);
                end
            end
            SC_IDENT: begin
                if (ch_idchar(c)) begin
                    emit_char(c);
                end else if (ch_sep(c)) begin
                    scan_st = SC_PATH;
                    emit_char(c);
                end else if (c == CH_PLUS) begin
                    reopen(CL_IDENT, c);
                end else begin
                    close_token(CL_ERROR);
                end
            end
            SC_PATH: begin
                if (ch_idchar(c) || ch_sep(c)) begin
                    emit_char(c);
                end else if (c == CH_PLUS) begin
                    reopen(CL_PATH, c);
                end else begin
                    close_token(CL_ERROR);
                end
            end
            SC_COMMENT: begin
                if (c == CH_LF || c == CH_CR || c == CH_NUL) scan_st = SC_START;
            end
            SC_QUOTE: begin
                if (c == CH_QUOTE) close_token(CL_PATH);
                else emit_char(c);
            end
            default: open_token(c);
        endcase
    endfunction

    // Queue the results one transferred item causes, flagging the last one
    function automatic void predict_tokens(input logic k, input logic [7:0] c);
        t_tok_res r;
        step_count = 0;
        if (k) close_token(state_class(scan_st));
        else if (c != CH_CTRL_Z) scan_data(c);
        if (step_count > 0) begin
            r = expected_tokens.pop_back();
            r.last = 1'b1;
            expected_tokens.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_tok_res got;
        t_tok_res want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.rkind = out_ch.result_kind;
            got.ch    = out_ch.char_value;
            got.cls   = out_ch.token_class;
            got.last  = out_ch.last_of_run;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind=%0d char=%h class=%0d last=%0d",
                             got.rkind, got.ch, got.cls, got.last);
            end else begin
                want = expected_tokens.pop_front();
                if (got.rkind !== want.rkind || got.ch !== want.ch ||
                    got.cls !== want.cls || got.last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected kind=%0d char=%h class=%0d last=%0d,",
                                  " got kind=%0d char=%h class=%0d last=%0d"},
                                 want.rkind, want.ch, want.cls, want.last,
                                 got.rkind, got.ch, got.cls, got.last);
                end
            end
        end
    end

    // Zero when not enabled or half the time, else a random wait
    function automatic int draw_wait(input bit on);
        if (!on || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) stall_left = draw_wait(recv_idle);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_item(input logic k, input logic [7:0] c);
        int gap;
        gap = draw_wait(send_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= k;
        in_ch.byte_value <= c;
        do @(posedge clk); while (!in_ch.ready);
        predict_tokens(k, c);
        if (k || c != CH_CTRL_Z) items_sent++;
    endtask

    task automatic send_eof();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send_item(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_tokens.size() != 0);
    endtask

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // One well-formed token with random content, or noise, then usually a separator
    task automatic send_random_token();
        string letters;
        logic [7:0] c;
        int n;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        case ($urandom_range(0, 11))
            0, 1: begin
                if ($urandom_range(0, 2) == 0) send_item(1'b0, pick_from("+-"));
                send_digits($urandom_range(1, 4));
                if ($urandom_range(0, 1)) begin
                    send_item(1'b0, CH_DOT);
                    send_digits($urandom_range(0, 3));
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_item(1'b0, CH_E);
                    if ($urandom_range(0, 1)) send_item(1'b0, pick_from("+-"));
                    send_digits($urandom_range(1, 3));
                end
            end
            2: begin
                send_item(1'b0, CH_DOT);
                send_digits($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    send_item(1'b0, CH_E);
                    send_digits($urandom_range(0, 2));
                end
            end
            3: begin
                // exponent marker followed by an arbitrary byte
                send_digits($urandom_range(1, 2));
                send_item(1'b0, CH_E);
                send_item(1'b0, 8'($urandom_range(0, 255)));
            end
            4: begin
                send_item(1'b0, CH_PLUS);
                send_digits($urandom_range(0, 2));
                send_item(1'b0, pick_from(letters));
            end
            5, 6: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) send_item(1'b0, pick_from(letters));
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) send_item(1'b0, pick_from("_-09az5Q"));
            end
            7: begin
                send_item(1'b0, pick_from("/\\:@aZ"));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_item(1'b0, pick_from("abz09_-\\/:.*AZ"));
            end
            8: begin
                send_item(1'b0, CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(0, 255));
                    send_item(1'b0, (c == CH_QUOTE) ? 8'h71 : c);
                end
                send_item(1'b0, CH_QUOTE);
            end
            9: begin
                send_item(1'b0, CH_HASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_LF || c == CH_CR || c == CH_NUL) c = 8'h63;
                    send_item(1'b0, c);
                end
                // close the comment with LF, CR or NUL
                n = $urandom_range(0, 2);
                send_item(1'b0, (n == 0) ? CH_LF : ((n == 1) ? CH_CR : CH_NUL));
            end
            10: send_item(1'b0, pick_from(";,()[]{}!=<>$%&?^|~"));
            default: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
            end
        endcase
        // separator: whitespace mostly, sometimes a plus, end of input, Ctrl-Z or none
        n = $urandom_range(0, 15);
        if (n < 9) send_item(1'b0, pick_from(" \t\n\r"));
        else if (n < 11) send_item(1'b0, CH_PLUS);
        else if (n == 11) send_eof();
        else if (n == 12) send_item(1'b0, CH_CTRL_Z);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // End of input at start, whitespace end, plus-number letter, dangling exponent, error
    task automatic test_token_ends();
        send_eof();
        send_text("+5a ");
        send_text("1e;");
        send_text("a!");
        wait_drained();
    endtask

    // Comment to line end, quoted text, end of input inside each
    task automatic test_comment_and_quote();
        send_text("#q\n");
        send_text("'x'");
        send_item(1'b0, CH_HASH);
        send_eof();
        send_item(1'b0, CH_QUOTE);
        send_eof();
        wait_drained();
    endtask

    // Ignored Ctrl-Z and the byte extremes as lone specials
    task automatic test_byte_extremes();
        send_item(1'b0, CH_CTRL_Z);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        wait_drained();
    endtask

    // Hold the receiver off while the sender streams without gaps
    task automatic test_back_pressure();
        int stop_at;
        stop_at   = items_sent + 40;
        send_idle = 1'b0;
        hold_left = 150;
        send_text("1e;2e;");
        while (items_sent < stop_at) send_random_token();
        wait_drained();
        send_idle = 1'b1;
    endtask

    // Back-to-back transfers on both sides
    task automatic test_steady_stream();
        int stop_at;
        stop_at   = items_sent + 60;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        while (items_sent < stop_at) send_random_token();
        wait_drained();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = items_sent + 320;
        while (items_sent < stop_at) send_random_token();
        send_eof();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        scan_st   = SC_START;
        fphase    = PH_MANT;
        plus_lead = 1'b0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= 1'b0;
        in_ch.byte_value <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_token_ends();
        test_comment_and_quote();
        test_byte_extremes();
        test_back_pressure();
        test_steady_stream();
        test_random_text();

        // let any stray result show up
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
